// File: sv/i2ctrf_pkg.sv
// Shared types and event codes for the I2C target register file.
`default_nettype none

package i2ctrf_pkg;

  // Bus event codes carried in the opcode field
  typedef enum logic [3:0] {
    OP_WR_ADDR   = 4'd0,
    OP_DATA_ACK  = 4'd1,
    OP_DATA_NACK = 4'd2,
    OP_STOP      = 4'd3,
    OP_RD_ADDR   = 4'd4,
    OP_SENT_ACK  = 4'd5,
    OP_SENT_NACK = 4'd6,
    OP_LAST_SENT = 4'd7,
    OP_OTHER     = 4'd8
  } opcode_t;

  // Input beat: one bus event with its received byte
  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] data_in;
  } in_item_t;

  // Output beat: acknowledge decision and transmit byte
  typedef struct packed {
    logic       ack_next;
    logic       tx_valid;
    logic [7:0] tx_data;
  } out_item_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic execute;
  } ctrl_cmd_t;

  localparam logic [6:0] TOP_INDEX_RESET = 7'd127;

endpackage

`default_nettype wire

// File: sv/i2c_target_register_file.sv
// Top level of the byte-event I2C target register file.
//
// The input channel (in_valid, in_stall, in_data) carries one bus event per
// beat: an opcode and the byte received from the controller. The output
// channel (out_valid, out_stall, out_data) returns exactly one result beat per
// event: the acknowledge decision for the next byte and, on read events, the
// register byte to send. The configuration channel (cfg_valid, cfg_ready,
// cfg_data) writes top_index; it is ready whenever reset is low.
// The accept edge issues the synchronous read of the register store at the
// pointer; the next edge updates pointer and store, loads the result register
// and raises out_valid. A new event is not taken while the controller is
// still executing the last one.
// Reset clears the pointer and the index flag, sets top_index to 127 and
// clears one fill flag per entry, so the whole store reads as zero at once.
// The input stalls during reset. While a result waits under out_stall, the
// result register holds and the input stalls until that beat is taken.
`default_nettype none

module i2c_target_register_file #(
  parameter int DEPTH = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire i2ctrf_pkg::in_item_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output i2ctrf_pkg::out_item_t     out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [6:0]           cfg_data
);
  import i2ctrf_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = !rst;

  i2ctrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  i2ctrf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: sv/i2ctrf_ctrl.sv
// Controller state machine: input acceptance, execute step and output valid.
`default_nettype none

module i2ctrf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output i2ctrf_pkg::ctrl_cmd_t   cmd
);
  import i2ctrf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   can_take;

  // Take a new beat only out of reset, when idle and the output register is free by the edge
  assign can_take = !rst && (state == ST_IDLE) && (!out_valid || !out_stall);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (can_take && in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_stall    = !can_take;
    cmd.accept  = can_take && in_valid;
    cmd.execute = (state == ST_EXEC);
    priority if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/i2ctrf_dpath.sv
// Datapath: register store, pointer, index flag, top index and result register.
`default_nettype none

module i2ctrf_dpath #(
  parameter int DEPTH = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire i2ctrf_pkg::ctrl_cmd_t cmd,
  input  wire i2ctrf_pkg::in_item_t  in_data,
  input  wire logic                  cfg_we,
  input  wire logic [6:0]            cfg_data,
  output i2ctrf_pkg::out_item_t      out_data
);
  import i2ctrf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] filled;
  logic [7:0]       rd_byte;
  logic             rd_filled;

  logic [PW-1:0]    ptr;
  logic [PW-1:0]    ptr_next;
  logic             expect_idx;
  logic             expect_idx_next;
  logic [6:0]       top_index;
  logic [8:0]       top_ext;

  logic [3:0]       op;
  logic [7:0]       data;

  logic             we;
  logic [PW-1:0]    idx_sel;
  logic             ack;
  logic             txv;
  logic [7:0]       tx;
  logic [PW-1:0]    mod_tab [256];

  assign top_ext = 9'(top_index);

  // Byte modulo depth as a constant table
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = PW'(g % DEPTH);
  end

  // Wrap to zero at the top index or the end of the store
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [8:0] top);
    logic [PW-1:0] r;
    if (9'(p) >= top) begin
      r = '0;
    end else if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Latch the event and read the store at the pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op        <= in_data.opcode;
      data      <= in_data.data_in;
      rd_byte   <= mem[ptr];
      rd_filled <= filled[ptr];
    end
  end

  // Decode the event against the current state
  always_comb begin
    we              = 1'b0;
    ack             = 1'b0;
    txv             = 1'b0;
    tx              = 8'd0;
    ptr_next        = ptr;
    expect_idx_next = expect_idx;
    idx_sel         = mod_tab[data];
    unique case (op)
      OP_WR_ADDR: begin
        expect_idx_next = 1'b1;
        ack             = 1'b1;
      end
      OP_DATA_ACK, OP_DATA_NACK: begin
        if (expect_idx) begin
          ptr_next        = (9'(idx_sel) > top_ext) ? '0 : idx_sel;
          expect_idx_next = 1'b0;
        end else begin
          we       = 1'b1;
          ptr_next = advance(ptr, top_ext);
        end
        ack = (9'(ptr_next) != top_ext);
      end
      OP_STOP, OP_SENT_NACK, OP_LAST_SENT: begin
        ack = 1'b1;
      end
      OP_RD_ADDR, OP_SENT_ACK: begin
        ack      = (9'(ptr) != top_ext);
        txv      = 1'b1;
        tx       = rd_filled ? rd_byte : 8'd0;
        ptr_next = advance(ptr, top_ext);
      end
      default: begin
        ack = 1'b0;
      end
    endcase
  end

  // Write the store on a data byte that is not the register index
  always_ff @(posedge clk) begin
    if (cmd.execute && we) begin
      mem[ptr] <= data;
    end
  end

  // Advance pointer, index flag and fill flags; load top index from configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      expect_idx <= 1'b0;
      filled     <= '0;
      top_index  <= TOP_INDEX_RESET;
    end else begin
      if (cmd.execute) begin
        ptr        <= ptr_next;
        expect_idx <= expect_idx_next;
        if (we) filled[ptr] <= 1'b1;
      end
      if (cfg_we) top_index <= cfg_data;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data.ack_next <= ack;
      out_data.tx_valid <= txv;
      out_data.tx_data  <= tx;
    end
  end

endmodule

`default_nettype wire
